/* design/olm_pkg.sv */
// ----------------------------------------------------------------------------
// olm_pkg
// Shared constants and types for the ordered list manager.
// ----------------------------------------------------------------------------
`default_nettype none
package olm_pkg;
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;

    localparam logic [IDX_W-1:0] LINK_NONE = IDX_W'(CAPACITY);

    typedef enum logic [3:0] {
        CMD_INS_HEAD  = 4'd0,
        CMD_INS_TAIL  = 4'd1,
        CMD_INS_POS   = 4'd2,
        CMD_INS_MATCH = 4'd3,
        CMD_RM_HEAD   = 4'd4,
        CMD_RM_TAIL   = 4'd5,
        CMD_RM_POS    = 4'd6,
        CMD_RM_MATCH  = 4'd7,
        CMD_DUMP      = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOTF  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]  command;
        logic signed [31:0] value;
        logic [6:0]  position;
        logic signed [31:0] match_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic signed [31:0] element;
        logic [6:0]  length;
        logic        last;
    } t_out;

    // memory port request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              lwr_en;
        logic [ADDR_W-1:0] lwr_addr;
        logic [IDX_W-1:0]  lwr_data;
        logic              vwr_en;
        logic [ADDR_W-1:0] vwr_addr;
        logic [31:0]       vwr_data;
    } t_mem_req;

    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic [31:0]      value;
    } t_mem_rsp;
endpackage
`default_nettype wire

/* design/olm_if.sv */
// ----------------------------------------------------------------------------
// olm_in_if / olm_out_if
// Valid/ready channels carrying command and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface olm_in_if;
    logic         valid;
    logic         ready;
    olm_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface olm_out_if;
    logic          valid;
    logic          ready;
    olm_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/olm_store.sv */
// ----------------------------------------------------------------------------
// olm_store
// Link and value memories; links sweep to a free chain after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module olm_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire olm_pkg::t_mem_req i_req,
    output olm_pkg::t_mem_rsp      o_rsp,
    output logic                   o_init_done
);
    logic [olm_pkg::IDX_W-1:0] r_links  [olm_pkg::CAPACITY];
    logic [31:0]               r_values [olm_pkg::CAPACITY];
    logic [olm_pkg::IDX_W-1:0] r_sweep;
    logic                      r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else if (!r_done) begin
            r_sweep <= r_sweep + 1'b1;
            if (r_sweep == olm_pkg::IDX_W'(olm_pkg::CAPACITY - 1)) r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_done) begin
            r_links[r_sweep[olm_pkg::ADDR_W-1:0]] <= r_sweep + 1'b1;
        end else if (i_req.lwr_en) begin
            r_links[i_req.lwr_addr] <= i_req.lwr_data;
        end
        if (i_req.vwr_en) r_values[i_req.vwr_addr] <= i_req.vwr_data;
        if (i_req.rd_en) begin
            o_rsp.link  <= r_links[i_req.rd_addr];
            o_rsp.value <= r_values[i_req.rd_addr];
        end
    end

    assign o_init_done = r_done;
endmodule
`default_nettype wire

/* design/ordered_list_manager_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_manager_core
// Linked list of signed values in a one-port-read memory with a free chain.
// ----------------------------------------------------------------------------
// Insert and remove first walk the list to the target entry, then update the free chain and links.
// A search that misses answers once the whole list is walked; a dump gives an item per cycle unless stalled.
// Throughput: one command at a time; the next is accepted once its last result item is taken.
// Reset: synchronous; a sweep over every slot chains the free slots, during
// which no command is accepted.
`default_nettype none
module ordered_list_manager_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    olm_in_if.sink     i_cmd,
    olm_out_if.source  o_res
);
    localparam int IW = olm_pkg::IDX_W;
    localparam int AW = olm_pkg::ADDR_W;
    localparam int CW = olm_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_WAIT  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        M_POS   = 2'd0,
        M_MATCH = 2'd1,
        M_DUMP  = 2'd2
    } t_mode;

    t_state             r_state, n_state;
    olm_pkg::t_in       r_in, n_in;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_free, n_free;
    logic [IW-1:0]      r_cur, n_cur;
    logic [IW-1:0]      r_prev, n_prev;
    logic [IW-1:0]      r_nxt, n_nxt;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_tgt, n_tgt;
    t_mode              r_mode, n_mode;
    logic               r_ins, n_ins;
    olm_pkg::t_out      r_out, n_out;
    logic               r_ovld, n_ovld;
    olm_pkg::t_mem_req  s_req;
    olm_pkg::t_mem_rsp  s_rsp;
    logic               s_init;
    logic [CW-1:0]      s_k;
    logic               s_hit;
    logic               s_adv;
    logic               s_fin;
    olm_pkg::t_status   s_st;

    olm_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (s_req),
        .o_rsp      (s_rsp),
        .o_init_done(s_init)
    );

    assign i_cmd.ready   = s_init && (r_state == S_IDLE) && !r_ovld;
    assign o_res.valid   = r_ovld;
    assign o_res.payload = r_out;

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_head  = r_head;
        n_free  = r_free;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_nxt   = r_nxt;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_tgt   = r_tgt;
        n_mode  = r_mode;
        n_ins   = r_ins;
        n_out   = r_out;
        n_ovld  = r_ovld && !o_res.ready;
        s_req   = '0;
        s_k     = '0;
        s_hit   = 1'b0;
        s_adv   = 1'b0;
        s_fin   = 1'b0;
        s_st    = olm_pkg::ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_in    = i_cmd.payload;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                s_req.rd_en   = 1'b1;
                s_req.rd_addr = r_head[AW-1:0];
                n_cur  = r_head;
                n_prev = olm_pkg::LINK_NONE;
                n_pos  = CW'(1);
                case (r_in.command)
                    olm_pkg::CMD_INS_HEAD, olm_pkg::CMD_INS_TAIL,
                    olm_pkg::CMD_INS_POS: begin
                        n_ins  = 1'b1;
                        n_mode = M_POS;
                        if (r_in.command == olm_pkg::CMD_INS_HEAD) s_k = CW'(1);
                        else if (r_in.command == olm_pkg::CMD_INS_TAIL) s_k = r_cnt + CW'(1);
                        else s_k = r_in.position;
                        n_tgt = s_k;
                        if (r_cnt >= CW'(olm_pkg::CAPACITY)) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_FULL;
                        end else if (s_k == '0 || s_k > r_cnt + CW'(1)) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_NOTF;
                        end else if (s_k == CW'(1)) begin
                            n_state = S_WAIT;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    olm_pkg::CMD_INS_MATCH: begin
                        n_ins  = 1'b1;
                        n_mode = M_MATCH;
                        if (r_cnt >= CW'(olm_pkg::CAPACITY)) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_FULL;
                        end else if (r_cnt == '0) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_NOTF;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    olm_pkg::CMD_RM_HEAD, olm_pkg::CMD_RM_TAIL,
                    olm_pkg::CMD_RM_POS: begin
                        n_ins  = 1'b0;
                        n_mode = M_POS;
                        if (r_in.command == olm_pkg::CMD_RM_HEAD) s_k = CW'(1);
                        else if (r_in.command == olm_pkg::CMD_RM_TAIL) s_k = r_cnt;
                        else s_k = r_in.position;
                        n_tgt = s_k;
                        if (r_cnt == '0) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_EMPTY;
                        end else if (s_k == '0 || s_k > r_cnt) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_NOTF;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    olm_pkg::CMD_RM_MATCH: begin
                        n_ins  = 1'b0;
                        n_mode = M_MATCH;
                        if (r_cnt == '0) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    olm_pkg::CMD_DUMP: begin
                        n_ins  = 1'b0;
                        n_mode = M_DUMP;
                        if (r_cnt == '0) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_EVAL;
                        end
                    end
                    default: begin
                        s_fin = 1'b1;
                        s_st  = olm_pkg::ST_NOTF;
                    end
                endcase
            end
            S_EVAL: begin
                case (r_mode)
                    M_DUMP: begin
                        if (!r_ovld || o_res.ready) begin
                            n_out  = '{olm_pkg::ST_DONE, s_rsp.value, r_cnt, r_pos == r_cnt};
                            n_ovld = 1'b1;
                            if (r_pos == r_cnt) n_state = S_IDLE;
                            else s_adv = 1'b1;
                        end
                    end
                    M_MATCH: begin
                        if (s_rsp.value == r_in.match_value) begin
                            s_hit = 1'b1;
                        end else if (r_pos == r_cnt) begin
                            s_fin = 1'b1;
                            s_st  = olm_pkg::ST_NOTF;
                        end else begin
                            s_adv = 1'b1;
                        end
                    end
                    default: begin
                        if (r_pos == r_tgt) s_hit = 1'b1;
                        else s_adv = 1'b1;
                    end
                endcase
                if (s_hit) begin
                    n_nxt   = s_rsp.link;
                    n_state = r_ins ? S_WAIT : S_FIN;
                end
                if (s_adv) begin
                    s_req.rd_en   = 1'b1;
                    s_req.rd_addr = s_rsp.link[AW-1:0];
                    n_prev = r_cur;
                    n_cur  = s_rsp.link;
                    n_pos  = r_pos + CW'(1);
                end
            end
            S_WAIT: begin
                s_req.rd_en   = 1'b1;
                s_req.rd_addr = r_free[AW-1:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                s_req.lwr_en = 1'b1;
                if (r_ins) begin
                    s_req.vwr_en   = 1'b1;
                    s_req.vwr_addr = r_free[AW-1:0];
                    s_req.vwr_data = r_in.value;
                    s_req.lwr_addr = r_free[AW-1:0];
                    s_req.lwr_data = r_cur;
                    n_free = s_rsp.link;
                    n_nxt  = r_free;
                    if (r_prev == olm_pkg::LINK_NONE) n_head = r_free;
                    n_cnt  = r_cnt + CW'(1);
                end else begin
                    s_req.lwr_addr = r_cur[AW-1:0];
                    s_req.lwr_data = r_free;
                    n_free = r_cur;
                    if (r_prev == olm_pkg::LINK_NONE) n_head = r_nxt;
                    n_cnt  = r_cnt - CW'(1);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_prev != olm_pkg::LINK_NONE) begin
                    s_req.lwr_en   = 1'b1;
                    s_req.lwr_addr = r_prev[AW-1:0];
                    s_req.lwr_data = r_nxt;
                end
                s_fin = 1'b1;
                s_st  = olm_pkg::ST_DONE;
            end
            default: n_state = S_IDLE;
        endcase
        if (s_fin) begin
            n_out   = '{s_st, 32'sd0, r_cnt, 1'b1};
            n_ovld  = 1'b1;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_in    <= '0;
            r_head  <= olm_pkg::LINK_NONE;
            r_free  <= '0;
            r_cur   <= olm_pkg::LINK_NONE;
            r_prev  <= olm_pkg::LINK_NONE;
            r_nxt   <= olm_pkg::LINK_NONE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_tgt   <= '0;
            r_mode  <= M_POS;
            r_ins   <= 1'b0;
            r_out   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_in    <= n_in;
            r_head  <= n_head;
            r_free  <= n_free;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_nxt   <= n_nxt;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_mode  <= n_mode;
            r_ins   <= n_ins;
            r_out   <= n_out;
            r_ovld  <= n_ovld;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_cmd.ready) else $error("accept while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(olm_pkg::CAPACITY)) else $error("count over capacity");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_res.ready) |=> (r_ovld && $stable(r_out)))
        else $error("result changed under stall");
    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_cnt != $past(r_cnt))) else $error("count not updated");
endmodule
`default_nettype wire
